// ===== sv/klvse_pkg.sv =====
// shared types and constants of the klv local set extractor
package klvse_pkg;

    localparam int unsigned LENGTH_BYTES_MAX = 7;
    localparam int unsigned KEY_BYTES        = 16;
    localparam int unsigned LEN_W            = 56;

    localparam logic [7:0] UKEY [KEY_BYTES] = '{
        8'h06, 8'h0E, 8'h2B, 8'h34, 8'h02, 8'h0B, 8'h01, 8'h01,
        8'h0E, 8'h01, 8'h03, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00
    };

    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_SEARCH  = 3'd1,
        PH_LEN     = 3'd2,
        PH_LENX    = 3'd3,
        PH_VALUE   = 3'd4,
        PH_PENDING = 3'd5
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [4:0]         key_progress;
        logic               key_at_offset_zero;
        logic [2:0]         length_bytes_left;
        logic [LEN_W-1:0]   length_accumulator;
        logic [LEN_W-1:0]   value_bytes_left;
        logic               first_value_pending;
    } t_state;

    typedef struct packed {
        logic [7:0]         value_byte;
        logic [LEN_W-1:0]   value_length;
        logic               first_of_unit;
        logic               last_of_unit;
    } t_result;

    localparam t_state STATE_RESET = '{
        PH_WAIT, 5'd0, 1'b0, 3'd0, 56'd0, 56'd0, 1'b0
    };

endpackage

// ===== sv/klv_local_set_extractor_top.sv =====
// klv local set extractor: input register, parser state and result register
//
// Takes demultiplexed packet bytes on the s_axis channel, one byte per
// transfer, and returns the value bytes of each key-length-value unit found
// on the metadata stream on the m_axis channel. Key and length bytes are
// consumed and never returned; a unit's value may span several packets.
// The stream number of the metadata packets is written through the cfg
// channel (ready out of reset); the user writes it only while the block is
// idle, the block itself does not enforce that. It resets to 1. Throughput
// is one byte per cycle while m_axis does not stall; the next parser state
// is combinational between the input register and the result register.
// When m_axis stalls, the result register and the input register both fill
// and s_axis_tready drops; it rises in the cycle m_axis_tready returns.
// Synchronous active-low reset empties both registers, returns the parser
// to waiting for a packet start and holds both ready signals low.
module klv_local_set_extractor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,     // metadata_stream
    // packet bytes in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // last_of_packet
    input  logic [8:0]  s_axis_tuser,   // stream number, first_of_packet
    // value bytes out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // value_byte, value_length
    output logic        m_axis_tlast,   // last_of_unit
    output logic        m_axis_tuser    // first_of_unit
);
    import klvse_pkg::*;

    logic [7:0]  r_meta;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [7:0]  r_in_sidx;
    logic        r_in_first;
    logic        r_in_last;
    t_state      r_state;
    t_state      n_state;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_res;
    logic        n_res_valid;
    logic        out_free;
    logic        proc;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign proc          = r_in_valid && out_free;
    assign s_axis_tready = i_rst_n && (!r_in_valid || out_free);
    assign o_cfg_ready   = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta <= 8'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_meta <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte  <= s_axis_tdata;
            r_in_sidx  <= s_axis_tuser[7:0];
            r_in_first <= s_axis_tuser[8];
            r_in_last  <= s_axis_tlast;
        end
    end

    klvse_step u_step (
        .i_state           (r_state),
        .i_data_byte       (r_in_byte),
        .i_stream_id       (r_in_sidx),
        .i_first_of_packet (r_in_first),
        .i_last_of_packet  (r_in_last),
        .i_meta_stream     (r_meta),
        .o_state           (n_state),
        .o_res_valid       (n_res_valid),
        .o_res             (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc && n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && n_res_valid) begin
            r_out <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.value_length, r_out.value_byte};
    assign m_axis_tlast  = r_out.last_of_unit;
    assign m_axis_tuser  = r_out.first_of_unit;

endmodule

// ===== sv/klvse_step.sv =====
// per-byte next state and result of the key, length and value parser
module klvse_step (
    input  klvse_pkg::t_state  i_state,
    input  logic [7:0]         i_data_byte,
    input  logic [7:0]         i_stream_id,
    input  logic               i_first_of_packet,
    input  logic               i_last_of_packet,
    input  logic [7:0]         i_meta_stream,
    output klvse_pkg::t_state  o_state,
    output logic               o_res_valid,
    output klvse_pkg::t_result o_res
);
    import klvse_pkg::*;

    t_state            s;
    logic              meta;
    logic [2:0]        cnt;
    logic [LEN_W-1:0]  len;
    logic              acc_ok;

    always_comb begin
        s           = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;
        meta        = (i_stream_id == i_meta_stream);
        cnt         = i_data_byte[2:0];
        len         = '0;
        acc_ok      = 1'b0;

        // packet start: a pending unit survives, anything half parsed is dropped
        if (i_first_of_packet) begin
            if (s.phase == PH_VALUE || s.phase == PH_PENDING) begin
                s.phase = meta ? PH_VALUE : PH_PENDING;
            end else if (meta) begin
                s.phase              = PH_SEARCH;
                s.key_progress       = 5'd0;
                s.key_at_offset_zero = 1'b1;
            end else begin
                s.phase = PH_WAIT;
            end
        end

        case (s.phase)
            PH_SEARCH: begin
                if (!s.key_progress[4] && i_data_byte == UKEY[s.key_progress[3:0]]) begin
                    s.key_progress = s.key_progress + 5'd1;
                end else begin
                    s.key_at_offset_zero = 1'b0;
                    s.key_progress       = (i_data_byte == UKEY[0]) ? 5'd1 : 5'd0;
                end
                if (s.key_progress[4]) begin
                    s.phase = i_last_of_packet ? PH_WAIT : PH_LEN;
                end else if (i_last_of_packet) begin
                    s.phase = PH_WAIT;
                end
            end
            PH_LEN: begin
                if (i_data_byte[7]) begin
                    if (cnt == 3'd0 || 32'(cnt) > LENGTH_BYTES_MAX || i_last_of_packet) begin
                        s.phase = PH_WAIT;
                    end else begin
                        s.length_bytes_left  = cnt;
                        s.length_accumulator = '0;
                        s.phase              = PH_LENX;
                    end
                end else if (i_data_byte == 8'd0
                             || (s.key_at_offset_zero && i_last_of_packet)) begin
                    s.phase = PH_WAIT;
                end else begin
                    acc_ok = 1'b1;
                    len    = {{(LEN_W-8){1'b0}}, i_data_byte};
                end
            end
            PH_LENX: begin
                s.length_accumulator = {s.length_accumulator[LEN_W-9:0], i_data_byte};
                if (s.length_bytes_left != 3'd0) begin
                    s.length_bytes_left = s.length_bytes_left - 3'd1;
                end
                if (s.length_bytes_left == 3'd0) begin
                    if (s.length_accumulator == '0) begin
                        s.phase = PH_WAIT;
                    end else begin
                        acc_ok = 1'b1;
                        len    = s.length_accumulator;
                    end
                end else if (i_last_of_packet) begin
                    s.phase = PH_WAIT;
                end
            end
            PH_VALUE: begin
                o_res_valid         = 1'b1;
                o_res.value_byte    = i_data_byte;
                o_res.value_length  = s.first_value_pending ? s.length_accumulator : '0;
                o_res.first_of_unit = s.first_value_pending;
                s.first_value_pending = 1'b0;
                if (s.value_bytes_left != '0) begin
                    s.value_bytes_left = s.value_bytes_left - 56'd1;
                end
                o_res.last_of_unit = (s.value_bytes_left == '0);
                if (o_res.last_of_unit) begin
                    s.phase = PH_WAIT;
                end else if (i_last_of_packet) begin
                    s.phase = PH_PENDING;
                end
            end
            default: begin
            end
        endcase

        // unit accepted: value bytes follow in this or a later packet
        if (acc_ok) begin
            s.length_accumulator  = len;
            s.value_bytes_left    = len;
            s.first_value_pending = 1'b1;
            s.phase               = i_last_of_packet ? PH_PENDING : PH_VALUE;
        end

        o_state = s;
    end

endmodule

// ===== sv/klvse_checker.sv =====
// port-level checks of the klv local set extractor, bound to the top level
module klvse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // a stalled result transfer keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // length only travels with the first value byte
    a_len_first_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:8] == 56'd0)
        else $error("length on a non-first value byte");

    // zero-length units are rejected, so a first byte always has a length
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:8] != 56'd0)
        else $error("first value byte with zero length");

    // a one-byte unit ends on its first byte
    a_single_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser && m_axis_tdata[63:8] == 56'd1 |-> m_axis_tlast)
        else $error("one-byte unit not closed");

    // nothing leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result present after reset");

endmodule

bind klv_local_set_extractor_top klvse_checker u_klvse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/klv_value_checker.sv =====
// checker for the klv extractor: tracks the parser, predicts value bytes, compares them
module klv_value_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,     // metadata_stream
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // last_of_packet
    input  logic [8:0]  s_axis_tuser,   // stream number, first_of_packet
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,   // value_byte, value_length
    input  logic        m_axis_tlast,   // last_of_unit
    input  logic        m_axis_tuser,   // first_of_unit
    input  logic        i_end_check,
    output int unsigned o_errors,
    output int unsigned o_outstanding
);

    import klvse_pkg::*;

    localparam logic [7:0] META_STREAM_RESET = 8'd1;

    logic [7:0]       meta_sid;
    t_phase           ph;
    logic [4:0]       key_pos;
    logic             key_at_zero;
    logic [2:0]       len_left;
    logic [LEN_W-1:0] len_acc;
    logic [LEN_W-1:0] val_left;
    logic             first_pend;

    t_result          value_q [$];
    int unsigned      err_cnt = 0;
    bit               end_seen = 1'b0;

    task automatic note_error();
        err_cnt++;
    endtask

    task automatic take_unit(input logic [LEN_W-1:0] len, input logic last);
        len_acc    = len;
        val_left   = len;
        first_pend = 1'b1;
        ph         = last ? PH_PENDING : PH_VALUE;
    endtask

    // one accepted packet byte through the parser
    task automatic advance_parser(input logic [7:0] b, input logic [7:0] sid,
                                  input logic first, input logic last);
        t_result    r;
        logic [2:0] cnt;
        logic       fin;
        if (first) begin
            if (ph == PH_VALUE || ph == PH_PENDING) begin
                ph = (sid == meta_sid) ? PH_VALUE : PH_PENDING;
            end else if (sid == meta_sid) begin
                ph          = PH_SEARCH;
                key_pos     = 5'd0;
                key_at_zero = 1'b1;
            end else begin
                ph = PH_WAIT;
            end
        end
        case (ph)
            PH_SEARCH: begin
                if (key_pos < KEY_BYTES && b == UKEY[key_pos[3:0]]) begin
                    key_pos = key_pos + 5'd1;
                end else begin
                    key_at_zero = 1'b0;
                    key_pos     = (b == UKEY[0]) ? 5'd1 : 5'd0;
                end
                if (key_pos >= KEY_BYTES)
                    ph = last ? PH_WAIT : PH_LEN;
                else if (last)
                    ph = PH_WAIT;
            end
            PH_LEN: begin
                if (b[7]) begin
                    cnt = b[2:0];
                    if (cnt == 3'd0 || cnt > LENGTH_BYTES_MAX || last) begin
                        ph = PH_WAIT;
                    end else begin
                        len_left = cnt;
                        len_acc  = '0;
                        ph       = PH_LENX;
                    end
                end else if (b == 8'd0 || (key_at_zero && last)) begin
                    ph = PH_WAIT;
                end else begin
                    take_unit(LEN_W'(b), last);
                end
            end
            PH_LENX: begin
                len_acc = {len_acc[LEN_W-9:0], b};
                if (len_left != 3'd0)
                    len_left = len_left - 3'd1;
                if (len_left == 3'd0) begin
                    if (len_acc == '0)
                        ph = PH_WAIT;
                    else
                        take_unit(len_acc, last);
                end else if (last) begin
                    ph = PH_WAIT;
                end
            end
            PH_VALUE: begin
                r.value_byte    = b;
                r.value_length  = first_pend ? len_acc : '0;
                r.first_of_unit = first_pend;
                first_pend      = 1'b0;
                if (val_left != '0)
                    val_left = val_left - 1'b1;
                fin            = (val_left == '0);
                r.last_of_unit = fin;
                if (fin)
                    ph = PH_WAIT;
                else if (last)
                    ph = PH_PENDING;
                value_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic check_value();
        t_result got;
        t_result want;
        got.value_byte    = m_axis_tdata[7:0];
        got.value_length  = m_axis_tdata[63:8];
        got.first_of_unit = m_axis_tuser;
        got.last_of_unit  = m_axis_tlast;
        if (value_q.size() == 0) begin
            note_error();
            if (err_cnt <= 10)
                $display("value byte with none expected: byte %h len %h first %b last %b",
                         got.value_byte, got.value_length, got.first_of_unit,
                         got.last_of_unit);
        end else begin
            want = value_q.pop_front();
            if (got !== want) begin
                note_error();
                if (err_cnt <= 10)
                    $display("value mismatch: byte %h/%h len %h/%h first %b/%b last %b/%b",
                             got.value_byte, want.value_byte,
                             got.value_length, want.value_length,
                             got.first_of_unit, want.first_of_unit,
                             got.last_of_unit, want.last_of_unit);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            meta_sid    = META_STREAM_RESET;
            ph          = PH_WAIT;
            key_pos     = 5'd0;
            key_at_zero = 1'b0;
            len_left    = 3'd0;
            len_acc     = '0;
            val_left    = '0;
            first_pend  = 1'b0;
            value_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                meta_sid = i_cfg_data;
            if (m_axis_tvalid && m_axis_tready)
                check_value();
            if (s_axis_tvalid && s_axis_tready)
                advance_parser(s_axis_tdata, s_axis_tuser[7:0], s_axis_tuser[8],
                               s_axis_tlast);
            if (i_end_check && !end_seen) begin
                end_seen = 1'b1;
                if (value_q.size() != 0) begin
                    note_error();
                    if (err_cnt <= 10)
                        $display("value bytes never delivered: %0d", value_q.size());
                end
            end
        end
        o_outstanding <= value_q.size();
        o_errors      <= err_cnt;
    end

endmodule

// ===== verif/tb.sv =====
// testbench top: clock, reset, packet stimulus, output back-pressure and verdict
module tb;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned PHASE_ITEMS  = 250;
    localparam int unsigned SETTLE_TICKS = 8;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data    = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tlast  = 1'b0;
    logic [8:0]  s_axis_tuser  = 9'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    logic        end_check     = 1'b0;
    int unsigned errors;
    int unsigned outstanding;

    logic [7:0]  pkt [$];
    logic [7:0]  meta_sid      = 8'd1;
    int unsigned owed          = 0;    // value bytes the current unit still needs
    int unsigned sent_items    = 0;
    int unsigned tx_idle_pct   = 0;
    int unsigned rx_idle_pct   = 0;
    int unsigned stall_left    = 0;

    klv_local_set_extractor_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    klv_value_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_end_check   (end_check),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // random output back-pressure, each stall burst of random length
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 15);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic int unsigned pick_idle();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 8;
            default: return 30;
        endcase
    endfunction

    function automatic void add_random(input int unsigned n);
        repeat (n) pkt.push_back(8'($urandom));
    endfunction

    function automatic void add_key(input int unsigned n);
        for (int i = 0; i < n; i++)
            pkt.push_back(klvse_pkg::UKEY[i]);
    endfunction

    // long-form length: head byte then n big-endian bytes
    function automatic void add_long(input logic [7:0] head, input logic [55:0] len,
                                     input int n);
        pkt.push_back(head);
        for (int i = n - 1; i >= 0; i--)
            pkt.push_back(len[8*i +: 8]);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic [7:0] sid,
                             input logic first, input logic last);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= {first, sid};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_items++;
    endtask

    // stream number only matters on the first byte, the rest carry noise there
    task automatic send_pkt(input logic [7:0] sid, input bit with_last);
        int unsigned n;
        n = pkt.size();
        for (int i = 0; i < n; i++)
            send_byte(pkt[i], (i == 0) ? sid : 8'($urandom), i == 0,
                      with_last && i == n - 1);
    endtask

    task automatic good_unit();
        int unsigned offs;
        int unsigned vlen;
        int unsigned cnt;
        int unsigned k;
        bit          long_form;
        pkt.delete();
        offs = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
        add_random(offs);
        add_key(16);
        vlen = ($urandom_range(0, 3) == 0) ? $urandom_range(128, 300) : $urandom_range(1, 60);
        long_form = (vlen > 127) || ($urandom_range(0, 2) == 0);
        if (long_form) begin
            cnt = (vlen > 255) ? $urandom_range(2, 7) : $urandom_range(1, 7);
            add_long({1'b1, 4'($urandom), 3'(cnt)}, 56'(vlen), cnt);
        end else begin
            pkt.push_back(8'(vlen));
        end
        k = $urandom_range(0, vlen + 8);
        if (k > vlen)
            k = vlen;
        add_random(k);
        // bytes after a finished unit are dropped by the parser
        if (k == vlen && $urandom_range(0, 1))
            add_random($urandom_range(1, 6));
        owed = vlen - k;
        if (k == 0 && offs == 0 && !long_form)
            owed = 0;
        send_pkt(meta_sid, 1'b1);
    endtask

    task automatic continue_unit(input bit drop_last);
        int unsigned n;
        pkt.delete();
        n = $urandom_range(1, (owed < 40) ? owed : 40);
        add_random(n);
        owed -= n;
        if (owed == 0 && $urandom_range(0, 2) == 0)
            add_random($urandom_range(1, 5));
        send_pkt(meta_sid, !drop_last);
    endtask

    task automatic finish_unit();
        while (owed != 0) continue_unit(1'b0);
    endtask

    task automatic other_packet();
        logic [7:0] sid;
        sid = meta_sid ^ 8'($urandom_range(1, 255));
        pkt.delete();
        if ($urandom_range(0, 1)) begin
            add_key(16);
            pkt.push_back(8'($urandom_range(1, 127)));
        end
        add_random($urandom_range(1, 20));
        send_pkt(sid, 1'b1);
    endtask

    task automatic broken_packet();
        int unsigned cnt;
        int unsigned n;
        pkt.delete();
        if ($urandom_range(0, 1))
            add_random($urandom_range(1, 6));
        cnt = $urandom_range(1, 7);
        case ($urandom_range(0, 8))
            0: add_key($urandom_range(1, 15));
            1: add_key(16);
            2: begin
                add_key(16);
                pkt.push_back(8'h00);
                add_random($urandom_range(0, 4));
            end
            3: begin
                add_key(16);
                pkt.push_back({1'b1, 4'($urandom), 3'b000});
                add_random($urandom_range(0, 4));
            end
            4: begin
                add_key(16);
                add_long({1'b1, 4'($urandom), 3'(cnt)}, 56'd0, cnt);
                add_random($urandom_range(0, 4));
            end
            5: begin
                add_key(16);
                add_long({1'b1, 4'($urandom), 3'(cnt)}, 56'($urandom), cnt - 1);
            end
            6: begin
                pkt.delete();
                add_key(16);
                pkt.push_back(8'($urandom_range(1, 127)));
            end
            7: begin
                // packet left open, the next first mark abandons it
                add_key($urandom_range(1, 16));
                if ($urandom_range(0, 1))
                    pkt.push_back(8'($urandom_range(128, 255)));
                send_pkt(meta_sid, 1'b0);
                return;
            end
            default: begin
                n = $urandom_range(1, 10);
                repeat (n)
                    send_byte(8'($urandom), $urandom_range(0, 1) ? meta_sid : 8'($urandom),
                              $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
                return;
            end
        endcase
        send_pkt(meta_sid, 1'b1);
    endtask

    task automatic random_item();
        int unsigned r;
        if (owed != 0) begin
            r = $urandom_range(0, 9);
            if (r < 2)
                other_packet();
            else
                continue_unit(r == 2);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60)
                good_unit();
            else if (r < 72)
                other_packet();
            else
                broken_packet();
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_stream(input logic [7:0] sid);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= sid;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        meta_sid = sid;
    endtask

    initial begin
        logic [7:0]  stream_plan [5];
        int unsigned phase_end;
        stream_plan = '{8'd0, 8'd255, 8'($urandom), 8'($urandom), 8'd1};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 10;
        rx_idle_pct = 10;
        // stray bytes with no packet open
        send_byte(8'hFF, meta_sid, 1'b0, 1'b0);
        send_byte(8'h00, meta_sid, 1'b0, 1'b1);
        // key at offset zero and a short length closing the packet: too short
        pkt.delete(); add_key(16); pkt.push_back(8'h05); send_pkt(meta_sid, 1'b1);
        // smallest unit, one value byte
        pkt.delete(); add_key(16); pkt.push_back(8'h01); pkt.push_back(8'h00);
        send_pkt(meta_sid, 1'b1);
        // zero short length, zero count, zero long value, length missing
        pkt.delete(); add_key(16); pkt.push_back(8'h00); send_pkt(meta_sid, 1'b1);
        pkt.delete(); add_key(16); pkt.push_back(8'h88); add_random(2); send_pkt(meta_sid, 1'b1);
        pkt.delete(); add_random(1); add_key(16); add_long(8'h81, 56'd0, 1);
        send_pkt(meta_sid, 1'b1);
        pkt.delete(); add_key(16); send_pkt(meta_sid, 1'b1);
        // seven length bytes, value split around a packet on another stream
        pkt.delete(); add_key(16); add_long(8'h87, 56'd2, 7); pkt.push_back(8'hFF);
        send_pkt(meta_sid, 1'b1);
        pkt.delete(); add_random(4); send_pkt(meta_sid ^ 8'hFF, 1'b1);
        pkt.delete(); pkt.push_back(8'h80); send_pkt(meta_sid, 1'b1);
        // long length cut short by the end of the packet
        pkt.delete(); add_random(3); add_key(16); pkt.push_back(8'h82); pkt.push_back(8'h01);
        send_pkt(meta_sid, 1'b1);
        // key after a false start, largest short length left pending
        pkt.delete(); pkt.push_back(8'h06); add_key(16); pkt.push_back(8'h7F);
        send_pkt(meta_sid, 1'b1);
        owed = 127;
        continue_unit(1'b1);
        finish_unit();

        for (int p = 0; p < 5; p++) begin
            finish_unit();
            drain();
            write_stream(stream_plan[p]);
            tx_idle_pct = (p == 4) ? 0 : pick_idle();
            rx_idle_pct = (p == 4) ? 0 : pick_idle();
            phase_end   = sent_items + PHASE_ITEMS;
            while (sent_items < phase_end) random_item();
        end

        // all-ones length: the unit never closes, so it comes last
        finish_unit();
        pkt.delete(); add_key(16); add_long(8'h87, {56{1'b1}}, 7); add_random(20);
        send_pkt(meta_sid, 1'b1);
        drain();

        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
